// ----- sv/tbrc_pkg.sv -----
// Package for the three-button repeat cursor: item and result structs,
// register map and shared constants. No dependencies.
`default_nettype none
package tbrc_pkg;

    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned TEXT_MAX   = 255;
    localparam int unsigned TEXT_LIM_I = (TEXT_MAX > 255) ? 255 : TEXT_MAX;

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [7:0]            TEXT_LIM = TEXT_LIM_I[7:0];

    localparam int unsigned ADDR_W = 4;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] REG_PRESS_DELAY   = 4'h0;
    localparam logic [ADDR_W-1:0] REG_REPEAT_RELOAD = 4'h4;
    localparam logic [ADDR_W-1:0] REG_MENU_LOW      = 4'h8;
    localparam logic [ADDR_W-1:0] REG_MENU_HIGH     = 4'hC;

    // Button codes
    localparam logic [1:0] BTN_NONE   = 2'd0;
    localparam logic [1:0] BTN_UP     = 2'd1;
    localparam logic [1:0] BTN_DOWN   = 2'd2;
    localparam logic [1:0] BTN_MIDDLE = 2'd3;

    // Mode codes
    localparam logic [1:0] MODE_MENU    = 2'd0;
    localparam logic [1:0] MODE_TEXT    = 2'd1;
    localparam logic [1:0] MODE_SLEEP   = 2'd2;
    localparam logic [1:0] MODE_CONNECT = 2'd3;

    typedef struct packed {
        logic       up_pressed;
        logic       down_pressed;
        logic       middle_pressed;
        logic [1:0] op_mode;
    } t_in_item;

    typedef struct packed {
        logic       action_flag;
        logic [1:0] fired_button;
        logic       click_pulse;
        logic [7:0] menu_position;
        logic [7:0] text_position;
    } t_out_item;

    typedef struct packed {
        logic [15:0] press_delay;
        logic [15:0] repeat_reload;
        logic [7:0]  menu_low;
        logic [7:0]  menu_high;
    } t_cfg;

endpackage
`default_nettype wire

// ----- sv/tbrc_cfg.sv -----
// Configuration register file with its APB-style access port.
// Depends on tbrc_pkg.
`default_nettype none
module tbrc_cfg
    import tbrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_delay   <= 16'd20;
            r_cfg.repeat_reload <= 16'd10;
            r_cfg.menu_low      <= 8'd0;
            r_cfg.menu_high     <= 8'd2;
        end else if (wr_en) begin
            case (paddr)
                REG_PRESS_DELAY:   r_cfg.press_delay   <= pwdata[15:0];
                REG_REPEAT_RELOAD: r_cfg.repeat_reload <= pwdata[15:0];
                REG_MENU_LOW:      r_cfg.menu_low      <= pwdata[7:0];
                REG_MENU_HIGH:     r_cfg.menu_high     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_PRESS_DELAY:   prdata = {16'd0, r_cfg.press_delay};
            REG_REPEAT_RELOAD: prdata = {16'd0, r_cfg.repeat_reload};
            REG_MENU_LOW:      prdata = {24'd0, r_cfg.menu_low};
            REG_MENU_HIGH:     prdata = {24'd0, r_cfg.menu_high};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- sv/tbrc_core.sv -----
// Button counters, action flag and cursors, with their one-tick update.
// Depends on tbrc_pkg.
`default_nettype none
module tbrc_core
    import tbrc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_advance,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_out_item     o_result
);

    localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [COUNT_BITS-1:0] r_up_cnt, r_down_cnt, r_mid_cnt;
    logic [COUNT_BITS-1:0] n_up_cnt, n_down_cnt, n_mid_cnt;
    logic                  r_action, n_action;
    logic [7:0]            r_menu, n_menu;
    logic [7:0]            r_text, n_text;

    logic [COUNT_BITS-1:0] reload;
    logic [COUNT_BITS-1:0] sel_cnt, served_cnt;
    logic                  sel_fire;
    logic [1:0]            fired;
    logic                  click;

    // Saturate the reload value to the counter range
    always_comb begin
        if (CMP_W'(i_cfg.repeat_reload) > CMP_W'(CNT_MAX)) begin
            reload = CNT_MAX;
        end else begin
            reload = COUNT_BITS'(i_cfg.repeat_reload);
        end
    end

    // Serve the highest-priority held button
    always_comb begin
        if (i_item.up_pressed) begin
            sel_cnt = r_up_cnt;
        end else if (i_item.down_pressed) begin
            sel_cnt = r_down_cnt;
        end else begin
            sel_cnt = r_mid_cnt;
        end
        sel_fire = CMP_W'(sel_cnt) >= CMP_W'(i_cfg.press_delay);
        if (sel_fire) begin
            served_cnt = reload;
        end else if (sel_cnt != CNT_MAX) begin
            served_cnt = sel_cnt + COUNT_BITS'(1);
        end else begin
            served_cnt = sel_cnt;
        end
    end

    always_comb begin
        n_up_cnt   = reload;
        n_down_cnt = reload;
        n_mid_cnt  = reload;
        n_action   = r_action;
        fired      = BTN_NONE;
        if (i_item.up_pressed) begin
            n_up_cnt = served_cnt;
            if (sel_fire) fired = BTN_UP;
        end else if (i_item.down_pressed) begin
            n_down_cnt = served_cnt;
            if (sel_fire) fired = BTN_DOWN;
        end else if (i_item.middle_pressed) begin
            n_mid_cnt = served_cnt;
            if (sel_fire) fired = BTN_MIDDLE;
        end else begin
            n_action   = 1'b0;
            n_up_cnt   = (r_up_cnt   != '0) ? '0 : COUNT_BITS'(1);
            n_down_cnt = (r_down_cnt != '0) ? '0 : COUNT_BITS'(1);
            n_mid_cnt  = (r_mid_cnt  != '0) ? '0 : COUNT_BITS'(1);
        end
        if (fired != BTN_NONE) n_action = 1'b1;
    end

    // Cursor moves and clicks on a fire
    always_comb begin
        n_menu = r_menu;
        n_text = r_text;
        click  = 1'b0;
        if (fired != BTN_NONE) begin
            case (i_item.op_mode)
                MODE_MENU: begin
                    if (fired == BTN_UP) begin
                        if (r_menu > i_cfg.menu_low) n_menu = r_menu - 8'd1;
                    end else if (fired == BTN_DOWN) begin
                        if (r_menu < i_cfg.menu_high) n_menu = r_menu + 8'd1;
                    end else begin
                        click = 1'b1;
                    end
                end
                MODE_TEXT: begin
                    if (fired == BTN_UP) begin
                        if (r_text != 8'd0) n_text = r_text - 8'd1;
                    end else if (fired == BTN_DOWN) begin
                        if (r_text < TEXT_LIM) n_text = r_text + 8'd1;
                    end else begin
                        click = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_cnt   <= '0;
            r_down_cnt <= '0;
            r_mid_cnt  <= '0;
            r_action   <= 1'b0;
            r_menu     <= 8'd0;
            r_text     <= 8'd0;
        end else if (i_advance) begin
            r_up_cnt   <= n_up_cnt;
            r_down_cnt <= n_down_cnt;
            r_mid_cnt  <= n_mid_cnt;
            r_action   <= n_action;
            r_menu     <= n_menu;
            r_text     <= n_text;
        end
    end

    assign o_result.action_flag   = n_action;
    assign o_result.fired_button  = fired;
    assign o_result.click_pulse   = click;
    assign o_result.menu_position = n_menu;
    assign o_result.text_position = n_text;

endmodule
`default_nettype wire

// ----- sv/three_button_repeat_cursor.sv -----
// Top level of the three-button repeat cursor: input register, core
// update and result register. Depends on tbrc_pkg, tbrc_cfg, tbrc_core.
`default_nettype none
// Button debounce with auto-repeat driving a menu cursor and a text cursor.
// Each input item is one sampling tick: three button levels and the mode.
// Up has priority over down, down over middle. A held button fires once its
// counter reaches press_delay, then reloads to repeat_reload for auto-repeat.
// Every item gives exactly one result item. An item lands in the input
// register, its update runs through one level of compare/increment logic
// in the core, and the result lands in the output register when that
// register is free; one item is taken every clock while the output side
// keeps up. When the output is stalled, the input register still takes
// one more item before o_in_stall rises. Registers (APB, byte address):
// 0x0 press_delay, 0x4 repeat_reload, 0x8 menu_low, 0xC menu_high;
// write them only while no item is in flight.
module three_button_repeat_cursor
    import tbrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input item channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_data,
    // result item channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_cfg      cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;
    t_out_item core_result;
    logic      out_free;
    logic      advance;
    logic      in_take;

    tbrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // Advance the held item into the core and the result register
    assign advance  = r_in_valid && out_free;
    // Hold off the sender only when the input register is full and stuck
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    tbrc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on acceptance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) r_in_item <= i_in_data;
        if (advance) r_out_item <= core_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // A fire always leaves the action flag set
    a_fire_sets_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fired_button != BTN_NONE)
            |-> o_out_data.action_flag)
        else $error("fire without action flag");

    // A click only comes from a middle fire
    a_click_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.click_pulse)
            |-> (o_out_data.fired_button == BTN_MIDDLE))
        else $error("click without middle fire");

    // Input side stalls only behind a stalled, full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // An advanced item always shows up as a result next cycle
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced item lost");

endmodule
`default_nettype wire
